// ----- rtl/spooky_hash_128_unit_defines.svh -----
// Assertion macros used by the checker file of the hash unit.
`ifndef SPOOKY_HASH_128_UNIT_DEFINES_SVH
`define SPOOKY_HASH_128_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SHU_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hash unit assertion violated");

// Next-cycle implication, checked on every rising edge outside reset.
`define SHU_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hash unit assertion violated");

`endif

// ----- rtl/shu_pkg.sv -----
// Shared types and constants of the 128-bit hash unit.
`timescale 1ns / 1ps
package shu_pkg;
	localparam int NUM_LANES = 12;
	localparam int QDEPTH = 2;
	localparam int SHORT_LIMIT = 192;
	localparam logic [63:0] SPK_CONST = 64'hdeadbeefdeadbeef;

	typedef logic [63:0] word_t;
	typedef logic [NUM_LANES-1:0][63:0] lanes_t;

	// Configuration register indexes.
	typedef enum logic [0:0] {
		REG_SEED_LOW  = 1'b0,
		REG_SEED_HIGH = 1'b1
	} cfg_reg_t;

	// One work item handed from the front part to the back part.
	typedef struct packed {
		logic   is_short;
		logic   first;
		logic   do_mix;
		logic   do_fin;
		lanes_t words;
	} op_t;
endpackage

// ----- rtl/shu_front.sv -----
// Front part: takes message words, builds blocks and issues mix and finish items.
`timescale 1ns / 1ps
module shu_front #(
	parameter int LENGTH_BITS = 48
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [63:0]            data_word,
	input  logic [3:0]             valid_bytes,
	input  logic                   last_word,
	input  logic [LENGTH_BITS-1:0] message_length,
	input  logic                   q_full,
	output logic                   push,
	output shu_pkg::op_t           push_op
);
	import shu_pkg::*;

	word_t                  buf_q [NUM_LANES];
	logic [3:0]             slot_q;
	logic [LENGTH_BITS-1:0] bytes_q;
	logic                   short_q;
	logic                   inmsg_q;
	logic                   first_q;

	logic                   acc;
	logic [3:0]             vb;
	word_t                  wm;
	logic                   start;
	logic                   sp;
	logic [3:0]             slot0;
	logic [3:0]             slot1;
	logic [3:0]             full;
	logic                   store;
	logic                   complete;
	logic [3:0]             addb;
	logic [6:0]             rem;
	logic [6:0]             rres;
	logic [LENGTH_BITS-1:0] bytes_new;
	word_t                  bw [NUM_LANES];
	word_t                  lenhi;
	word_t                  w0f;
	word_t                  w1f;
	logic                   first_flag;

	assign in_ready = !q_full;
	assign acc = in_valid && in_ready;

	// Classify the word and work out slot, remainder and length.
	always_comb begin
		vb = (valid_bytes > 4'd8) ? 4'd8 : valid_bytes;
		for (int b = 0; b < 8; b++) begin
			wm[8*b +: 8] = (4'(b) < vb) ? data_word[8*b +: 8] : 8'h00;
		end
		start = !inmsg_q;
		sp = start ? (message_length < LENGTH_BITS'(SHORT_LIMIT)) : short_q;
		slot0 = start ? 4'd0 : slot_q;
		full = sp ? 4'd4 : 4'd12;
		store = !last_word || (vb != 4'd0);
		slot1 = slot0 + {3'b000, store};
		complete = store && (slot1 == full);
		addb = last_word ? vb : 4'd8;
		if (!store) begin
			rem = {slot0, 3'b000};
		end else if (complete) begin
			rem = 7'd0;
		end else begin
			rem = {slot0, 3'b000} + {3'b000, addb};
		end
		bytes_new = (start ? '0 : bytes_q) + LENGTH_BITS'(addb);
		lenhi = {bytes_new[7:0], 56'h0};
		first_flag = start || first_q;
		for (int i = 0; i < NUM_LANES; i++) begin
			bw[i] = (store && slot0 == 4'(i)) ? wm : buf_q[i];
		end
	end

	// Build the item for the back part.
	always_comb begin
		push_op = '0;
		push_op.is_short = sp;
		push_op.first = first_flag;
		push_op.do_fin = last_word;
		push_op.do_mix = complete;
		rres = rem;
		w0f = '0;
		w1f = '0;
		if (!sp) begin
			if (complete) begin
				for (int i = 0; i < NUM_LANES; i++) push_op.words[i] = bw[i];
			end else begin
				for (int i = 0; i < NUM_LANES - 1; i++) begin
					push_op.words[i] = (4'(i) < slot1) ? bw[i] : '0;
				end
				push_op.words[NUM_LANES-1] = {1'b0, rem, 56'h0};
			end
		end else if (complete) begin
			for (int i = 0; i < 4; i++) push_op.words[i] = bw[i];
			push_op.words[4] = SPK_CONST;
			push_op.words[5] = SPK_CONST + lenhi;
		end else begin
			if (rem >= 7'd16) begin
				push_op.do_mix = 1'b1;
				push_op.words[0] = bw[0];
				push_op.words[1] = bw[1];
				rres = rem - 7'd16;
				w0f = (slot1 > 4'd2) ? bw[2] : '0;
				w1f = (slot1 > 4'd3) ? bw[3] : '0;
			end else begin
				w0f = (slot1 > 4'd0) ? bw[0] : '0;
				w1f = (slot1 > 4'd1) ? bw[1] : '0;
			end
			push_op.words[4] = (rres == 7'd0) ? SPK_CONST : w0f;
			push_op.words[5] = ((rres == 7'd0) ? SPK_CONST : w1f) + lenhi;
		end
	end

	assign push = acc && (complete || last_word);

	// Message tracking state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
			bytes_q <= '0;
			short_q <= 1'b0;
			inmsg_q <= 1'b0;
			first_q <= 1'b0;
		end else if (acc) begin
			inmsg_q <= !last_word;
			short_q <= sp;
			slot_q <= (complete || last_word) ? 4'd0 : slot1;
			bytes_q <= bytes_new;
			first_q <= first_flag && !push;
		end
	end

	// Block word buffer.
	always_ff @(posedge clk) begin
		if (acc && store) begin
			buf_q[slot0] <= wm;
		end
	end
endmodule

// ----- rtl/shu_queue.sv -----
// Short queue of work items between the front and back parts.
`timescale 1ns / 1ps
module shu_queue (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  shu_pkg::op_t push_op,
	input  logic         pop,
	output logic         full,
	output logic         head_valid,
	output shu_pkg::op_t head
);
	import shu_pkg::*;

	localparam int AW = $clog2(QDEPTH);

	op_t           mem_q [QDEPTH];
	logic [AW-1:0] wr_q;
	logic [AW-1:0] rd_q;
	logic [AW:0]   cnt_q;

	assign full = (cnt_q == (AW+1)'(QDEPTH));
	assign head_valid = (cnt_q != '0);
	assign head = mem_q[rd_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

	// Item storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_op;
		end
	end
endmodule

// ----- rtl/shu_back.sv -----
// Back part: runs the lane mixing, the end rounds and holds the result.
`timescale 1ns / 1ps
module shu_back (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         head_valid,
	input  shu_pkg::op_t head,
	output logic         pop,
	input  logic [63:0]  seed_low,
	input  logic [63:0]  seed_high,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [63:0]  hash_low,
	output logic [63:0]  hash_high
);
	import shu_pkg::*;

	lanes_t      s_q;
	logic [5:0]  cnt_q;
	logic [3:0]  idx_q;
	logic        infin_q;
	logic        started_q;
	logic        out_valid_q;
	word_t       hlo_q;
	word_t       hhi_q;

	lanes_t      seeded;
	lanes_t      v0;
	lanes_t      nxt;
	logic        in_mix;
	logic        phase_last;
	logic        out_busy;
	logic        advance;
	logic        fin_done;

	function automatic word_t rotl(word_t x, logic [5:0] k);
		logic [127:0] d;
		d = {x, x} << k;
		return d[127:64];
	endfunction

	function automatic logic [5:0] mix_rot(logic [3:0] i);
		case (i)
			4'd0: return 6'd11;  4'd1: return 6'd32;  4'd2: return 6'd43;
			4'd3: return 6'd31;  4'd4: return 6'd17;  4'd5: return 6'd28;
			4'd6: return 6'd39;  4'd7: return 6'd57;  4'd8: return 6'd55;
			4'd9: return 6'd54;  4'd10: return 6'd22; 4'd11: return 6'd46;
			default: return 6'd0;
		endcase
	endfunction

	function automatic logic [5:0] endp_rot(logic [3:0] i);
		case (i)
			4'd0: return 6'd44;  4'd1: return 6'd15;  4'd2: return 6'd34;
			4'd3: return 6'd21;  4'd4: return 6'd38;  4'd5: return 6'd33;
			4'd6: return 6'd10;  4'd7: return 6'd13;  4'd8: return 6'd38;
			4'd9: return 6'd53;  4'd10: return 6'd42; 4'd11: return 6'd54;
			default: return 6'd0;
		endcase
	endfunction

	function automatic logic [5:0] smix_rot(logic [3:0] j);
		case (j)
			4'd0: return 6'd50;  4'd1: return 6'd52;  4'd2: return 6'd30;
			4'd3: return 6'd41;  4'd4: return 6'd54;  4'd5: return 6'd48;
			4'd6: return 6'd38;  4'd7: return 6'd37;  4'd8: return 6'd62;
			4'd9: return 6'd34;  4'd10: return 6'd5;  4'd11: return 6'd36;
			default: return 6'd0;
		endcase
	endfunction

	function automatic logic [5:0] send_rot(logic [3:0] j);
		case (j)
			4'd0: return 6'd15;  4'd1: return 6'd52;  4'd2: return 6'd26;
			4'd3: return 6'd51;  4'd4: return 6'd28;  4'd5: return 6'd9;
			4'd6: return 6'd47;  4'd7: return 6'd54;  4'd8: return 6'd32;
			4'd9: return 6'd25;  4'd10: return 6'd63;
			default: return 6'd0;
		endcase
	endfunction

	// One step of the twelve-lane block mix.
	function automatic lanes_t long_step(lanes_t s, word_t d, logic [3:0] i);
		logic [3:0] p;
		logic [3:0] n;
		logic [3:0] i2;
		logic [3:0] i10;
		p = (i == 4'd0) ? 4'd11 : i - 4'd1;
		n = (i == 4'd11) ? 4'd0 : i + 4'd1;
		i2 = (i >= 4'd10) ? i - 4'd10 : i + 4'd2;
		i10 = (i >= 4'd2) ? i - 4'd2 : i + 4'd10;
		s[i] = s[i] + d;
		s[i2] = s[i2] ^ s[i10];
		s[p] = s[p] ^ s[i];
		s[i] = rotl(s[i], mix_rot(i));
		s[p] = s[p] + s[n];
		return s;
	endfunction

	// One step of an end round.
	function automatic lanes_t end_step(lanes_t h, logic [3:0] i);
		logic [3:0] p;
		logic [3:0] n;
		logic [3:0] i2;
		p = (i == 4'd0) ? 4'd11 : i - 4'd1;
		n = (i == 4'd11) ? 4'd0 : i + 4'd1;
		i2 = (i >= 4'd10) ? i - 4'd10 : i + 4'd2;
		h[p] = h[p] + h[n];
		h[i2] = h[i2] ^ h[p];
		h[n] = rotl(h[n], endp_rot(i));
		return h;
	endfunction

	// One step of the four-lane short mix.
	function automatic lanes_t short_step(lanes_t h, logic [3:0] j);
		logic [1:0] x;
		logic [1:0] y;
		logic [1:0] z;
		x = j[1:0] + 2'd2;
		y = j[1:0] + 2'd3;
		z = j[1:0];
		h[x] = rotl(h[x], smix_rot(j));
		h[x] = h[x] + h[y];
		h[z] = h[z] ^ h[x];
		return h;
	endfunction

	// One step of the short end rounds.
	function automatic lanes_t sfin_step(lanes_t h, logic [3:0] j);
		logic [1:0] t;
		logic [1:0] u;
		t = j[1:0] + 2'd3;
		u = j[1:0] + 2'd2;
		h[t] = h[t] ^ h[u];
		h[u] = rotl(h[u], send_rot(j));
		h[t] = h[t] + h[u];
		return h;
	endfunction

	// Lane values at the start of the current step.
	always_comb begin
		seeded = '0;
		if (head.is_short) begin
			seeded[0] = seed_low;
			seeded[1] = seed_high;
			seeded[2] = SPK_CONST;
			seeded[3] = SPK_CONST;
		end else begin
			for (int i = 0; i < NUM_LANES; i += 3) begin
				seeded[i] = seed_low;
				seeded[i+1] = seed_high;
				seeded[i+2] = SPK_CONST;
			end
		end
		v0 = (head.first && !started_q) ? seeded : s_q;
	end

	// Step datapath.
	always_comb begin
		in_mix = head.do_mix && !infin_q;
		nxt = v0;
		if (in_mix) begin
			if (!head.is_short) begin
				nxt = long_step(v0, head.words[idx_q], idx_q);
				phase_last = (cnt_q == 6'd11);
			end else begin
				if (cnt_q == 6'd0) begin
					nxt[2] = nxt[2] + head.words[0];
					nxt[3] = nxt[3] + head.words[1];
				end
				for (int k = 0; k < 3; k++) begin
					nxt = short_step(nxt, 4'({2'b00, cnt_q[1:0]} * 4'd3) + 4'(k));
				end
				if (cnt_q == 6'd3) begin
					nxt[0] = nxt[0] + head.words[2];
					nxt[1] = nxt[1] + head.words[3];
				end
				phase_last = (cnt_q == 6'd3);
			end
		end else begin
			if (!head.is_short) begin
				if (cnt_q == 6'd0 && !head.do_mix) begin
					for (int i = 0; i < NUM_LANES; i++) nxt[i] = nxt[i] + head.words[i];
				end
				nxt = end_step(nxt, idx_q);
				phase_last = (cnt_q == 6'd35);
			end else begin
				if (cnt_q == 6'd0) begin
					nxt[2] = nxt[2] + head.words[4];
					nxt[3] = nxt[3] + head.words[5];
				end
				nxt = sfin_step(nxt, cnt_q[3:0]);
				phase_last = (cnt_q == 6'd10);
			end
		end
		out_busy = out_valid_q && !out_ready;
		fin_done = !in_mix && phase_last;
		advance = head_valid && !(fin_done && out_busy);
		pop = advance && phase_last && (!in_mix || !head.do_fin);
	end

	// Sequencing, lane state and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			idx_q <= '0;
			infin_q <= 1'b0;
			started_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				started_q <= !pop;
				if (phase_last) begin
					cnt_q <= '0;
					idx_q <= '0;
					infin_q <= in_mix && !pop;
				end else begin
					cnt_q <= cnt_q + 6'd1;
					idx_q <= (idx_q == 4'd11) ? 4'd0 : idx_q + 4'd1;
				end
			end
			if (advance && fin_done) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			s_q <= nxt;
		end
		if (advance && fin_done) begin
			hlo_q <= nxt[0];
			hhi_q <= nxt[1];
		end
	end

	assign out_valid = out_valid_q;
	assign hash_low = hlo_q;
	assign hash_high = hhi_q;
endmodule

// ----- rtl/spooky_hash_128_unit.sv -----
// Result: a message's hash is taken from lanes 0 and 1 after the end rounds that follow
// its final word; they run one step a cycle but stall on the last step while a result is held.
// Input: one word per cycle while in_ready is high, that is while the queue is not full;
// the back unit mixes a 96-byte block, and a 32-byte short group, one step at a time.
// Reset: arst_n clears seeds to zero, empties the queue and drops any pending result.
`timescale 1ns / 1ps
module spooky_hash_128_unit #(
	parameter int LENGTH_BITS = 48
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic [0:0]             cfg_index,
	input  logic [63:0]            cfg_data,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [63:0]            data_word,
	input  logic [3:0]             valid_bytes,
	input  logic                   last_word,
	input  logic [LENGTH_BITS-1:0] message_length,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [63:0]            hash_low,
	output logic [63:0]            hash_high
);
	import shu_pkg::*;

	logic  [63:0] seed_low_q;
	logic  [63:0] seed_high_q;
	logic         q_full;
	logic         push;
	op_t          push_op;
	logic         pop;
	logic         head_valid;
	op_t          head;

	// Seed registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_low_q <= '0;
			seed_high_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_SEED_LOW: seed_low_q <= cfg_data;
				REG_SEED_HIGH: seed_high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	shu_front #(.LENGTH_BITS(LENGTH_BITS)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.data_word(data_word), .valid_bytes(valid_bytes),
		.last_word(last_word), .message_length(message_length),
		.q_full(q_full), .push(push), .push_op(push_op)
	);

	shu_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(push), .push_op(push_op), .pop(pop),
		.full(q_full), .head_valid(head_valid), .head(head)
	);

	shu_back u_back (
		.clk(clk), .arst_n(arst_n),
		.head_valid(head_valid), .head(head), .pop(pop),
		.seed_low(seed_low_q), .seed_high(seed_high_q),
		.out_valid(out_valid), .out_ready(out_ready),
		.hash_low(hash_low), .hash_high(hash_high)
	);
endmodule

// ----- rtl/shu_checker.sv -----
// Port-level checks of the hash unit and their binding to the top level.
`timescale 1ns / 1ps
`include "spooky_hash_128_unit_defines.svh"
module shu_checker #(
	parameter int LENGTH_BITS = 48
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   cfg_wr_en,
	input logic [0:0]             cfg_index,
	input logic [63:0]            cfg_data,
	input logic                   in_valid,
	input logic                   in_ready,
	input logic [63:0]            data_word,
	input logic [3:0]             valid_bytes,
	input logic                   last_word,
	input logic [LENGTH_BITS-1:0] message_length,
	input logic                   out_valid,
	input logic                   out_ready,
	input logic [63:0]            hash_low,
	input logic [63:0]            hash_high
);
	logic [2:0] outst_q;
	logic       msg_in;
	logic       msg_out;

	assign msg_in = in_valid && in_ready && last_word;
	assign msg_out = out_valid && out_ready;

	// Count messages whose last word went in and whose hash has not come out.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outst_q <= '0;
		end else begin
			outst_q <= outst_q + 3'(msg_in) - 3'(msg_out);
		end
	end

	`SHU_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(hash_low) && $stable(hash_high))
	`SHU_ASSERT_IMP(a_no_spurious, out_valid, outst_q != 3'd0)
	`SHU_ASSERT_IMP(a_bounded, 1'b1, outst_q <= 3'd3)
endmodule

bind spooky_hash_128_unit shu_checker #(.LENGTH_BITS(LENGTH_BITS)) u_shu_checker (.*);
